/* hdl/peh_pkg.sv */
// shared constants, codes and types of the programmable edge histogram
package peh_pkg;

	localparam int NUM_BINS    = 7;
	localparam int COUNT_BITS  = 48;
	localparam int EDGE_REGS   = 7;
	localparam int EDGE_BITS   = 31;
	localparam int SAMPLE_BITS = 32;
	localparam int BIN_BITS    = 3;
	localparam int FUNC_BITS   = 2;
	localparam int STATUS_BITS = 3;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 31;
	localparam int USED_BITS   = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_LAST = CFG_IDX_BITS'(EDGE_REGS - 1);
	localparam logic [CFG_IDX_BITS-1:0] REG_BINS_USED = CFG_IDX_BITS'(EDGE_REGS);

	localparam logic [USED_BITS-1:0] BINS_USED_RESET = USED_BITS'(7);

	typedef logic [EDGE_BITS-1:0] edge_t;

	// lower edges after reset: 0.0, 1.0, ... 6.0 in Q16.16
	localparam edge_t EDGE_RESET [EDGE_REGS] = '{
		31'd0, 31'd65536, 31'd131072, 31'd196608,
		31'd262144, 31'd327680, 31'd393216
	};

	typedef enum logic [FUNC_BITS-1:0] {
		FN_INSERT = 2'd0,
		FN_CLEAR  = 2'd1,
		FN_READ   = 2'd2
	} func_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_COUNTED   = 3'd0,
		ST_NEGATIVE  = 3'd1,
		ST_BELOW     = 3'd2,
		ST_CLEARED   = 3'd3,
		ST_READ_DONE = 3'd4
	} status_t;

	// classified operation handed from front to back
	typedef struct packed {
		status_t             status;
		logic [BIN_BITS-1:0] bin;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

/* hdl/peh_ifs.sv */
// channel interfaces: item input, result output, configuration write
interface peh_in_if;
	import peh_pkg::*;
	logic                          valid;
	logic                          ready;
	logic [FUNC_BITS-1:0]          func;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [BIN_BITS-1:0]           bin_select;

	modport source (output valid, func, sample, bin_select, input ready);
	modport sink (input valid, func, sample, bin_select, output ready);
endinterface

interface peh_out_if;
	import peh_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [BIN_BITS-1:0]    bin;
	logic [COUNT_BITS-1:0]  bin_count;
	logic [COUNT_BITS-1:0]  total_count;

	modport source (output valid, status, bin, bin_count, total_count, input ready);
	modport sink (input valid, status, bin, bin_count, total_count, output ready);
endinterface

interface peh_cfg_if;
	import peh_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/programmable_edge_histogram_top.sv */
// top level of the programmable edge histogram
//
// channel   dir  word                                   accepted when
// items     in   func, sample, bin_select               items.valid && items.ready
// results   out  status, bin, bin_count, total_count    results.valid && results.ready
// cfg       in   index (0..6 edges, 7 bins_used), data  cfg.valid && cfg.ready (always ready)
//
// one word per cycle while results.ready is high; queue slot, then result register
// the front compares the sample against all edges at once, the back does one
// 48-bit saturating increment per cycle, unless stalled, on the addressed counter
// reset clears counters, total, queue and result valid, and loads the default edges
// a two-entry queue lets the front keep taking words while a result waits;
// items.ready drops only when that queue is full
// func code 3 is taken and dropped with no result
module programmable_edge_histogram_top import peh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	peh_in_if.sink    items,
	peh_out_if.source results,
	peh_cfg_if.sink   cfg
);

	// front to queue
	logic   push;
	op_t    push_op;
	// queue to back
	logic   pop;
	op_t    head;
	qstat_t qstat;

	// accept and classify against the edge registers
	peh_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.cfg     (cfg),
		.qstat   (qstat),
		.push    (push),
		.push_op (push_op)
	);

	// decouples front and back stalls
	peh_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	// counter update and result register
	peh_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.results (results)
	);

endmodule

/* hdl/peh_front.sv */
// front end: edge registers, item accept and bin classification
module peh_front import peh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	peh_in_if.sink       items,
	peh_cfg_if.sink      cfg,
	input  qstat_t       qstat,
	output logic         push,
	output op_t          push_op
);

	edge_t                edges_q [EDGE_REGS];
	logic [USED_BITS-1:0] bins_used_q;
	logic [USED_BITS-1:0] n_act;
	logic                 found;
	logic [BIN_BITS-1:0]  hit_bin;
	logic                 accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < EDGE_REGS; i++) edges_q[i] <= EDGE_RESET[i];
			bins_used_q <= BINS_USED_RESET;
		end else if (cfg.valid) begin
			if (cfg.index <= REG_EDGE_LAST) begin
				edges_q[cfg.index] <= cfg.data[EDGE_BITS-1:0];
			end else if (cfg.index == REG_BINS_USED) begin
				bins_used_q <= cfg.data[USED_BITS-1:0];
			end
		end
	end

	// clamp bins in use to 1..NUM_BINS
	always_comb begin
		if (bins_used_q == '0) begin
			n_act = USED_BITS'(1);
		end else if (bins_used_q > USED_BITS'(NUM_BINS)) begin
			n_act = USED_BITS'(NUM_BINS);
		end else begin
			n_act = bins_used_q;
		end
	end

	// parallel edge compares, highest hit wins
	always_comb begin
		found   = 1'b0;
		hit_bin = '0;
		for (int i = 0; i < NUM_BINS; i++) begin
			if (USED_BITS'(i) < n_act && edges_q[i] <= items.sample[EDGE_BITS-1:0]) begin
				found   = 1'b1;
				hit_bin = BIN_BITS'(i);
			end
		end
	end

	assign items.ready = !qstat.full;
	assign accept      = items.valid && items.ready;

	always_comb begin
		push           = 1'b0;
		push_op.status = ST_COUNTED;
		push_op.bin    = '0;
		unique case (func_t'(items.func))
			FN_INSERT: begin
				push = accept;
				if (items.sample[SAMPLE_BITS-1]) begin
					push_op.status = ST_NEGATIVE;
				end else if (!found) begin
					push_op.status = ST_BELOW;
				end else begin
					push_op.status = ST_COUNTED;
					push_op.bin    = hit_bin;
				end
			end
			FN_CLEAR: begin
				push           = accept;
				push_op.status = ST_CLEARED;
			end
			FN_READ: begin
				push           = accept;
				push_op.status = ST_READ_DONE;
				push_op.bin    = items.bin_select;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

/* hdl/peh_queue.sv */
// short queue of classified operations between front and back
module peh_queue import peh_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  op_t    push_op,
	input  logic   pop,
	output op_t    head,
	output qstat_t qstat
);

	op_t                  slots_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign qstat.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/peh_back.sv */
// back end: bin counters, running total and result register
module peh_back import peh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  op_t      head,
	input  qstat_t   qstat,
	output logic     pop,
	peh_out_if.source results
);

	logic [COUNT_BITS-1:0]  counters_q [NUM_BINS];
	logic [COUNT_BITS-1:0]  total_q;
	logic                   out_valid_q;
	status_t                out_status_q;
	logic [BIN_BITS-1:0]    out_bin_q;
	logic [COUNT_BITS-1:0]  out_count_q;
	logic [COUNT_BITS-1:0]  out_total_q;

	logic                   in_range;
	logic [COUNT_BITS-1:0]  cur;
	logic                   sat;
	logic [COUNT_BITS-1:0]  cnt_next;
	logic [COUNT_BITS-1:0]  tot_next;

	assign pop = !qstat.empty && (!out_valid_q || results.ready);

	assign in_range = (head.bin < BIN_BITS'(NUM_BINS));
	assign cur      = in_range ? counters_q[head.bin] : '0;
	assign sat      = (cur == COUNT_MAX);
	assign cnt_next = sat ? cur : cur + 1'b1;
	assign tot_next = (!sat && total_q != COUNT_MAX) ? total_q + 1'b1 : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) counters_q[i] <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				unique case (head.status)
					ST_COUNTED: begin
						counters_q[head.bin] <= cnt_next;
						total_q              <= tot_next;
					end
					ST_CLEARED: begin
						for (int i = 0; i < NUM_BINS; i++) counters_q[i] <= '0;
						total_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_status_q <= head.status;
			unique case (head.status)
				ST_COUNTED: begin
					out_bin_q   <= head.bin;
					out_count_q <= cnt_next;
					out_total_q <= tot_next;
				end
				ST_READ_DONE: begin
					out_bin_q   <= head.bin;
					out_count_q <= cur;
					out_total_q <= total_q;
				end
				ST_CLEARED: begin
					out_bin_q   <= '0;
					out_count_q <= '0;
					out_total_q <= '0;
				end
				default: begin
					out_bin_q   <= '0;
					out_count_q <= '0;
					out_total_q <= total_q;
				end
			endcase
		end
	end

	assign results.valid       = out_valid_q;
	assign results.status      = out_status_q;
	assign results.bin         = out_bin_q;
	assign results.bin_count   = out_count_q;
	assign results.total_count = out_total_q;

endmodule

/* tb/programmable_edge_histogram_checker.sv */
// checker for the programmable edge histogram: predicts every result word and compares it
module programmable_edge_histogram_checker import peh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	peh_in_if    items,
	peh_out_if   results,
	peh_cfg_if   cfg,
	output int   errors,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t               status;
		logic [BIN_BITS-1:0]   bin;
		logic [COUNT_BITS-1:0] bin_count;
		logic [COUNT_BITS-1:0] total_count;
	} hist_word_t;

	// own copy of the registers and the counters
	edge_t                 edge_lo [EDGE_REGS];
	logic [USED_BITS-1:0]  used_reg;
	logic [COUNT_BITS-1:0] bin_tally [NUM_BINS];
	logic [COUNT_BITS-1:0] grand_total;

	hist_word_t pending_words [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns histogram checker: %s", $realtime, msg);
		errors++;
	endtask

	// one item in, updates the counters; returns 0 when the item makes no word
	function automatic bit predict_histogram(input logic [FUNC_BITS-1:0] fn,
		input logic [SAMPLE_BITS-1:0] smp, input logic [BIN_BITS-1:0] sel,
		output hist_word_t word);
		int                  live;
		bit                  hit;
		logic [BIN_BITS-1:0] pick;
		word.status      = ST_COUNTED;
		word.bin         = '0;
		word.bin_count   = '0;
		word.total_count = grand_total;
		case (fn)
			FN_INSERT: begin
				live = int'(used_reg);
				if (live < 1)
					live = 1;
				if (live > NUM_BINS)
					live = NUM_BINS;
				if (smp[SAMPLE_BITS-1]) begin
					word.status = ST_NEGATIVE;
					return 1'b1;
				end
				hit  = 1'b0;
				pick = '0;
				// highest edge in use that is not above the sample
				for (int i = 0; i < live; i++) begin
					if (SAMPLE_BITS'(edge_lo[i]) <= smp) begin
						hit  = 1'b1;
						pick = BIN_BITS'(i);
					end
				end
				if (!hit) begin
					word.status = ST_BELOW;
					return 1'b1;
				end
				// a saturated bin holds the total as well
				if (bin_tally[pick] != COUNT_MAX) begin
					bin_tally[pick]++;
					if (grand_total != COUNT_MAX)
						grand_total++;
				end
				word.bin         = pick;
				word.bin_count   = bin_tally[pick];
				word.total_count = grand_total;
				return 1'b1;
			end
			FN_CLEAR: begin
				for (int i = 0; i < NUM_BINS; i++)
					bin_tally[i] = '0;
				grand_total      = '0;
				word.status      = ST_CLEARED;
				word.total_count = '0;
				return 1'b1;
			end
			FN_READ: begin
				word.status = ST_READ_DONE;
				word.bin    = sel;
				if (int'(sel) < NUM_BINS)
					word.bin_count = bin_tally[sel];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		hist_word_t want;
		hist_word_t made;
		if (!arst_n) begin
			edge_lo     = EDGE_RESET;
			used_reg    = BINS_USED_RESET;
			for (int i = 0; i < NUM_BINS; i++)
				bin_tally[i] = '0;
			grand_total = '0;
			pending_words.delete();
			errors      = 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (int'(cfg.index) < EDGE_REGS)
					edge_lo[cfg.index] = cfg.data;
				else if (cfg.index == REG_BINS_USED)
					used_reg = cfg.data[USED_BITS-1:0];
			end
			if (results.valid && results.ready) begin
				if (pending_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word status %0d bin %0d count %0h total %0h",
						results.status, results.bin, results.bin_count, results.total_count));
				end else begin
					want = pending_words.pop_front();
					if (results.status !== want.status)
						report_mismatch($sformatf("status got %0d expected %0d",
							results.status, want.status));
					if (results.bin !== want.bin)
						report_mismatch($sformatf("bin got %0d expected %0d",
							results.bin, want.bin));
					if (results.bin_count !== want.bin_count)
						report_mismatch($sformatf("bin_count got %0h expected %0h",
							results.bin_count, want.bin_count));
					if (results.total_count !== want.total_count)
						report_mismatch($sformatf("total_count got %0h expected %0h",
							results.total_count, want.total_count));
				end
			end
			if (items.valid && items.ready) begin
				if (predict_histogram(items.func, items.sample, items.bin_select, made))
					pending_words.push_back(made);
			end
			outstanding <= pending_words.size();
		end
	end

endmodule

/* tb/programmable_edge_histogram_top_tb.sv */
// testbench top of the programmable edge histogram: stimulus, result stalls and verdict
module programmable_edge_histogram_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import peh_pkg::*;

	// func code the block takes and drops without a word
	localparam logic [FUNC_BITS-1:0] FN_UNUSED = 2'd3;

	localparam int RESET_CYCLES    = 8;
	localparam int DRAIN_PAUSE     = 4;    // a result passes the queue slot and the result register
	localparam int HOLD_OFF_CYCLES = 300;  // long receiver stall
	localparam int QUIET_LIMIT     = 2000; // cycles without any handshake
	localparam int IDLE_PCT        = 12;

	typedef enum {EDGES_ASCENDING, EDGES_TOP, EDGES_SCRAMBLED} edge_plan_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	peh_in_if  items_if ();
	peh_out_if results_if ();
	peh_cfg_if cfg_if ();

	int check_errors;
	int words_outstanding;

	// idle rates of both sides, changed per phase
	int in_idle_pct  = IDLE_PCT;
	int out_idle_pct = IDLE_PCT;

	// receiver stall requests from the stimulus, served by the ready process
	int hold_offs_asked = 0;
	int hold_offs_done  = 0;

	// what the stimulus last programmed, used to aim samples at the edges
	edge_t                edge_shadow [EDGE_REGS];
	logic [USED_BITS-1:0] used_shadow;

	int quiet_cycles = 0;

	always #1 clk = ~clk;

	programmable_edge_histogram_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	programmable_edge_histogram_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items_if),
		.results     (results_if),
		.cfg         (cfg_if),
		.errors      (check_errors),
		.outstanding (words_outstanding)
	);

	// watchdog: any handshake resets the count
	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("programmable_edge_histogram_top_tb: done, errors");
			$finish;
		end
	end

	// result receiver: random stalls, plus a long hold-off when one is asked
	initial begin
		results_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_offs_asked != hold_offs_done) begin
				hold_offs_done++;
				results_if.ready <= 1'b0;
				// counted here so the sender keeps offering and the queue fills up
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				results_if.ready <= ($urandom_range(99) >= out_idle_pct);
			end
		end
	end

	// offer one item word with random idle cycles ahead of it, wait for the handshake
	task automatic push_item(input logic [FUNC_BITS-1:0] fn, input logic [SAMPLE_BITS-1:0] smp,
		input logic [BIN_BITS-1:0] sel);
		while ($urandom_range(99) < in_idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid      <= 1'b1;
		items_if.func       <= fn;
		items_if.sample     <= smp;
		items_if.bin_select <= sel;
		do @(posedge clk); while (!items_if.ready);
	endtask

	// stop offering and wait until every predicted word has come back
	task automatic drain();
		items_if.valid <= 1'b0;
		do @(posedge clk); while (words_outstanding != 0);
		// a dropped func 3 word may still be in flight
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// valid stays high across back-to-back writes, lowered once by the caller
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	// write all edges and bins_used from the shadow copy; block must be idle
	task automatic load_config();
		for (int i = 0; i < EDGE_REGS; i++)
			write_reg(CFG_IDX_BITS'(i), CFG_DATA_BITS'(edge_shadow[i]));
		write_reg(REG_BINS_USED, CFG_DATA_BITS'(used_shadow));
		cfg_if.valid <= 1'b0;
	endtask

	task automatic program_edges(input edge_plan_t plan, input logic [USED_BITS-1:0] used);
		logic [31:0] acc;
		case (plan)
			EDGES_ASCENDING: begin
				// strictly rising, spaced so samples near edges stay meaningful
				acc = $urandom_range(0, 1 << 18);
				for (int i = 0; i < EDGE_REGS; i++) begin
					edge_shadow[i] = edge_t'(acc);
					acc = acc + $urandom_range(1, 1 << 21);
				end
			end
			EDGES_TOP: begin
				// bin 0 from zero, the rest crowded at the top of the range
				for (int i = 0; i < EDGE_REGS; i++)
					edge_shadow[i] = 31'h7FFF_FFFF - edge_t'((EDGE_REGS - 1 - i) * $urandom_range(1, 4));
				edge_shadow[0] = '0;
			end
			default: begin
				// out of order and repeated edges
				for (int i = 0; i < EDGE_REGS; i++) begin
					if (i > 0 && $urandom_range(3) == 0)
						edge_shadow[i] = edge_shadow[$urandom_range(i - 1)];
					else if ($urandom_range(4) == 0)
						edge_shadow[i] = edge_t'($urandom);
					else
						edge_shadow[i] = edge_t'($urandom_range(0, 1 << 22));
				end
			end
		endcase
		used_shadow = used;
		load_config();
	endtask

	// random item words: mostly inserts aimed at the edges, some reads, rare clears and unused codes
	task automatic random_burst(input int count);
		int                     pick;
		logic [FUNC_BITS-1:0]   fn;
		logic [SAMPLE_BITS-1:0] smp;
		logic [BIN_BITS-1:0]    sel;
		logic [31:0]            near;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 72)
				fn = FN_INSERT;
			else if (pick < 86)
				fn = FN_READ;
			else if (pick < 90)
				fn = FN_CLEAR;
			else if (pick < 94)
				fn = FN_UNUSED;
			else
				fn = FN_INSERT;
			sel  = BIN_BITS'($urandom_range(7));
			near = 32'(edge_shadow[$urandom_range(EDGE_REGS - 1)]);
			pick = $urandom_range(99);
			if (pick < 40)
				smp = near + 32'($urandom_range(4)) - 32'd2;
			else if (pick < 60)
				smp = near + 32'($urandom_range(1 << 20));
			else if (pick < 70)
				smp = $urandom | 32'h8000_0000;
			else if (pick < 75)
				smp = '0;
			else if (pick < 78)
				smp = 32'h7FFF_FFFF;
			else
				smp = $urandom;
			push_item(fn, smp, sel);
		end
	endtask

	initial begin
		// known values on every input before reset is released
		items_if.valid      <= 1'b0;
		items_if.func       <= FN_INSERT;
		items_if.sample     <= '0;
		items_if.bin_select <= '0;
		cfg_if.valid        <= 1'b0;
		cfg_if.index        <= '0;
		cfg_if.data         <= '0;
		edge_shadow = EDGE_RESET;
		used_shadow = BINS_USED_RESET;

		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed part on the reset edges 0.0 .. 6.0
		push_item(FN_INSERT, 32'h0000_0000, '0); // zero sample lands on a zero edge
		push_item(FN_INSERT, 32'h0000_FFFF, '0); // just under 1.0
		push_item(FN_INSERT, 32'h0001_0000, '0); // exactly on an edge
		push_item(FN_INSERT, 32'h0005_FFFF, '0);
		push_item(FN_INSERT, 32'h0006_0000, '0); // last edge
		push_item(FN_INSERT, 32'h7FFF_FFFF, '0); // beyond the last edge
		push_item(FN_INSERT, 32'hFFFF_FFFF, '1); // smallest negative
		push_item(FN_INSERT, 32'h8000_0000, '1); // most negative
		push_item(FN_READ, '0, 3'd0);
		push_item(FN_READ, '0, 3'd6);
		push_item(FN_READ, '0, 3'd7);             // select beyond the bins
		push_item(FN_UNUSED, 32'hFFFF_FFFF, '1);  // dropped, no word
		push_item(FN_READ, '0, 3'd1);
		push_item(FN_CLEAR, 32'h7FFF_FFFF, '1);
		push_item(FN_READ, '0, 3'd6);
		push_item(FN_INSERT, 32'h7FFF_FFFF, '0);
		drain();

		// three bins in use with a raised first edge; counters survive the change
		edge_shadow[0] = 31'h0001_0000;
		edge_shadow[1] = 31'h0002_0000;
		edge_shadow[2] = 31'h7FFF_FFFF;
		used_shadow    = 3'd3;
		load_config();
		push_item(FN_INSERT, 32'h0000_0000, '0); // zero below the first edge
		push_item(FN_INSERT, 32'h0000_FFFF, '0); // below range
		push_item(FN_INSERT, 32'h7FFF_FFFF, '0); // on the top edge
		push_item(FN_READ, '0, 3'd6);            // bin not in use keeps its count
		drain();

		// bins_used of zero acts as one
		used_shadow = 3'd0;
		load_config();
		push_item(FN_INSERT, 32'h0001_0000, '0);
		push_item(FN_INSERT, 32'h7FFF_FFFF, '0);
		drain();

		// random phase on rising edges, all bins
		program_edges(EDGES_ASCENDING, 3'd7);
		random_burst(130);
		drain();

		// receiver holds off while the sender keeps going, so the input stalls
		program_edges(EDGES_ASCENDING, USED_BITS'($urandom_range(1, 6)));
		hold_offs_asked++;
		random_burst(120);
		drain();

		// edges at the top of the range, no idling on either side
		in_idle_pct  = 0;
		out_idle_pct = 0;
		program_edges(EDGES_TOP, 3'd7);
		random_burst(120);
		drain();
		in_idle_pct  = IDLE_PCT;
		out_idle_pct = IDLE_PCT;

		// scrambled and repeated edges, any bins_used
		program_edges(EDGES_SCRAMBLED, USED_BITS'($urandom_range(0, 7)));
		random_burst(130);
		drain();

		if (check_errors == 0) begin
			$display("programmable_edge_histogram_top_tb: done, clean");
		end else begin
			$display("programmable_edge_histogram_top_tb: done, errors");
		end
		$finish;
	end

endmodule
